[sv/tlc_pkg.sv]
// shared constants, types and coefficient tables of the two-channel lux calculator
package tlc_pkg;

    localparam int COUNT_BITS_DEF      = 16;
    localparam int RATIO_FRAC_BITS_DEF = 10;

    // configuration register indexes
    localparam int   CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAIN_HIGH = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INTEG_MS  = 1'b1;

    localparam int TIME_BITS   = 9;
    localparam int INTEG_RESET = 13;

    // count scaling: count * 402 / integration time, x16 at low gain
    localparam int SCALE_NUM  = 402;
    localparam int SCALE_BITS = 9;
    localparam int GAIN_SHIFT = 4;

    // coefficients are Q0.16
    localparam int COEF_BITS      = 12;
    localparam int COEF_FRAC_BITS = 16;
    localparam int BAND_BITS      = 3;

    localparam int LUX_BITS       = 21;
    localparam int LUX_TDATA_BITS = 24;
    localparam logic [LUX_BITS-1:0] LUX_MAX = '1;
    localparam int LUX_GAIN       = 151;
    localparam int LUX_GAIN_BITS  = 8;
    localparam int LUX_DIV        = 100;

    // values at or above this limit saturate after the divide by 100
    localparam int Y_BITS    = 28;
    localparam int DIV_LIMIT = LUX_DIV * (2 ** LUX_BITS);

    // floor(2^35 / 100), estimate is low by at most one
    localparam int RECIP_100   = 343597383;
    localparam int RECIP_BITS  = 29;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic valid;
        logic sat;
    } tlc_tag_t;

    function automatic logic [COEF_BITS-1:0] coef_b(input logic [BAND_BITS-1:0] band);
        logic [COEF_BITS-1:0] v;
        case (band)
            3'd0:    v = 12'd1992;
            3'd1:    v = 12'd2130;
            3'd2:    v = 12'd2300;
            3'd3:    v = 12'd2497;
            3'd4:    v = 12'd1468;
            3'd5:    v = 12'd839;
            3'd6:    v = 12'd96;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic logic [COEF_BITS-1:0] coef_m(input logic [BAND_BITS-1:0] band);
        logic [COEF_BITS-1:0] v;
        case (band)
            3'd0:    v = 12'd1783;
            3'd1:    v = 12'd2884;
            3'd2:    v = 12'd3565;
            3'd3:    v = 12'd4089;
            3'd4:    v = 12'd2032;
            3'd5:    v = 12'd1003;
            3'd6:    v = 12'd73;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

endpackage

[sv/tlc_scaler.sv]
// pipelined restoring divider: both counts times 402 over the integration time
module tlc_scaler import tlc_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  tlc_tag_t                         in_tag,
    input  logic [COUNT_BITS-1:0]            c0,
    input  logic [COUNT_BITS-1:0]            c1,
    input  logic [TIME_BITS-1:0]             t,
    output tlc_tag_t                         out_tag,
    output logic [COUNT_BITS+SCALE_BITS-1:0] s0,
    output logic [COUNT_BITS+SCALE_BITS-1:0] s1
);

    localparam int QB = COUNT_BITS + SCALE_BITS;

    tlc_tag_t             tag_reg [QB];
    logic [QB-1:0]        d0_reg  [QB];
    logic [QB-1:0]        d1_reg  [QB];
    logic [QB-1:0]        q0_reg  [QB];
    logic [QB-1:0]        q1_reg  [QB];
    logic [TIME_BITS-1:0] r0_reg  [QB];
    logic [TIME_BITS-1:0] r1_reg  [QB];

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < QB; i++) begin : g_stage
        tlc_tag_t             tag_cur;
        logic [QB-1:0]        d0_cur, d1_cur, q0_cur, q1_cur;
        logic [TIME_BITS-1:0] r0_cur, r1_cur;
        logic [TIME_BITS:0]   trial0, trial1;
        logic                 ge0, ge1;

        if (i == 0) begin : g_first
            assign tag_cur = in_tag;
            assign d0_cur  = QB'(c0) * QB'(SCALE_NUM);
            assign d1_cur  = QB'(c1) * QB'(SCALE_NUM);
            assign q0_cur  = '0;
            assign q1_cur  = '0;
            assign r0_cur  = '0;
            assign r1_cur  = '0;
        end else begin : g_next
            assign tag_cur = tag_reg[i-1];
            assign d0_cur  = d0_reg[i-1];
            assign d1_cur  = d1_reg[i-1];
            assign q0_cur  = q0_reg[i-1];
            assign q1_cur  = q1_reg[i-1];
            assign r0_cur  = r0_reg[i-1];
            assign r1_cur  = r1_reg[i-1];
        end

        always_comb begin
            trial0 = {r0_cur, d0_cur[QB-1]};
            trial1 = {r1_cur, d1_cur[QB-1]};
            ge0    = trial0 >= {1'b0, t};
            ge1    = trial1 >= {1'b0, t};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i] <= '0;
            end else if (en) begin
                tag_reg[i] <= tag_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d0_reg[i] <= d0_cur << 1;
                d1_reg[i] <= d1_cur << 1;
                q0_reg[i] <= {q0_cur[QB-2:0], ge0};
                q1_reg[i] <= {q1_cur[QB-2:0], ge1};
                r0_reg[i] <= ge0 ? TIME_BITS'(trial0 - {1'b0, t}) : TIME_BITS'(trial0);
                r1_reg[i] <= ge1 ? TIME_BITS'(trial1 - {1'b0, t}) : TIME_BITS'(trial1);
            end
        end
    end

    assign out_tag = tag_reg[QB-1];
    assign s0      = q0_reg[QB-1];
    assign s1      = q1_reg[QB-1];

endmodule

[sv/tlc_ratio.sv]
// pipelined divider for the infrared to broadband ratio, capped below 2.0
module tlc_ratio import tlc_pkg::*; #(
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  tlc_tag_t                         in_tag,
    input  logic [COUNT_BITS+SCALE_BITS-1:0] s0,
    input  logic [COUNT_BITS+SCALE_BITS-1:0] s1,
    output tlc_tag_t                         out_tag,
    output logic [COUNT_BITS+SCALE_BITS-1:0] s0_out,
    output logic [RATIO_FRAC_BITS:0]         ratio
);

    localparam int QB = COUNT_BITS + SCALE_BITS;
    localparam int F  = RATIO_FRAC_BITS;
    localparam int NS = F + 1;

    tlc_tag_t      tag_reg  [NS];
    logic [QB-1:0] s0_reg   [NS];
    logic [QB-1:0] r_reg    [NS];
    logic [F:0]    q_reg    [NS];
    logic          over_reg [NS];

    // stage j resolves quotient bit F-j; the first stage also flags s1 >= 2*s0
    for (genvar j = 0; j < NS; j++) begin : g_stage
        tlc_tag_t      tag_cur;
        logic [QB-1:0] s0_cur;
        logic [F:0]    q_cur;
        logic [QB:0]   trial;
        logic          over_cur;
        logic          ge;

        if (j == 0) begin : g_first
            assign tag_cur  = in_tag;
            assign s0_cur   = s0;
            assign q_cur    = '0;
            assign trial    = {1'b0, s1};
            assign over_cur = {1'b0, s1} >= {s0, 1'b0};
        end else begin : g_next
            assign tag_cur  = tag_reg[j-1];
            assign s0_cur   = s0_reg[j-1];
            assign q_cur    = q_reg[j-1];
            assign trial    = {r_reg[j-1], 1'b0};
            assign over_cur = over_reg[j-1];
        end

        assign ge = trial >= {1'b0, s0_cur};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[j] <= '0;
            end else if (en) begin
                tag_reg[j] <= tag_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s0_reg[j]   <= s0_cur;
                over_reg[j] <= over_cur;
                q_reg[j]    <= {q_cur[F-1:0], ge};
                r_reg[j]    <= ge ? QB'(trial - {1'b0, s0_cur}) : QB'(trial);
            end
        end
    end

    assign out_tag = tag_reg[NS-1];
    assign s0_out  = s0_reg[NS-1];
    assign ratio   = over_reg[NS-1] ? '1 : q_reg[NS-1];

endmodule

[sv/tlc_lux.sv]
// band pick, coefficient, products, divide by 100 and saturation, eight stages
module tlc_lux import tlc_pkg::*; #(
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             gain_high,
    input  tlc_tag_t                         in_tag,
    input  logic [COUNT_BITS+SCALE_BITS-1:0] s0,
    input  logic [RATIO_FRAC_BITS:0]         ratio,
    output tlc_tag_t                         out_tag,
    output logic [LUX_BITS-1:0]              lux
);

    localparam int F   = RATIO_FRAC_BITS;
    localparam int QB  = COUNT_BITS + SCALE_BITS;
    localparam int SB  = QB + GAIN_SHIFT;
    localparam int KB  = COEF_BITS + F;
    localparam int MB  = COEF_BITS + F + 1;
    localparam int P1B = KB + SB;
    localparam int P2B = P1B + LUX_GAIN_BITS;
    localparam int YSH = COEF_FRAC_BITS + F;
    localparam int YW  = P2B - YSH;
    localparam int EW  = (YW > Y_BITS) ? YW : Y_BITS;
    localparam int QPB = Y_BITS + RECIP_BITS;
    localparam int NT  = 8;

    // band limits, ratio rounded to the nearest Q1.F step
    localparam int LIM0 = ((1 << F) + 4) / 8;
    localparam int LIM1 = ((1 << F) + 2) / 4;
    localparam int LIM2 = ((3 << F) + 4) / 8;
    localparam int LIM3 = ((1 << F) + 1) / 2;
    localparam int LIM4 = ((61 << F) + 50) / 100;
    localparam int LIM5 = ((4 << F) + 2) / 5;
    localparam int LIM6 = ((13 << F) + 5) / 10;

    tlc_tag_t tag_reg [NT];

    logic [COEF_BITS-1:0] b1_reg, m1_reg;
    logic [F:0]           ratio1_reg;
    logic [SB-1:0]        s0sc1_reg, s0sc2_reg, s0sc3_reg;
    logic [KB-1:0]        hi2_reg, k3_reg;
    logic [MB-1:0]        lo2_reg;
    logic [P1B-1:0]       p1_4_reg;
    logic [P2B-1:0]       p2_5_reg;
    logic [Y_BITS-1:0]    y6_reg, y7_reg;
    logic [LUX_BITS-1:0]  qe7_reg, lux8_reg;
    logic                 zero1_reg, zero2_reg, zero3_reg, zero4_reg;
    logic                 zero5_reg, zero6_reg, zero7_reg;
    logic                 big6_reg, big7_reg;

    logic [BAND_BITS-1:0] band;
    logic [EW-1:0]        y_full;
    logic                 big;
    logic [QPB-1:0]       qprod;
    logic [Y_BITS-1:0]    rem;
    logic [LUX_BITS-1:0]  qfix;
    logic [LUX_BITS-1:0]  lux_next;

    always_comb begin
        if (ratio <= (F+1)'(LIM0)) begin
            band = 3'd0;
        end else if (ratio <= (F+1)'(LIM1)) begin
            band = 3'd1;
        end else if (ratio <= (F+1)'(LIM2)) begin
            band = 3'd2;
        end else if (ratio <= (F+1)'(LIM3)) begin
            band = 3'd3;
        end else if (ratio <= (F+1)'(LIM4)) begin
            band = 3'd4;
        end else if (ratio <= (F+1)'(LIM5)) begin
            band = 3'd5;
        end else if (ratio <= (F+1)'(LIM6)) begin
            band = 3'd6;
        end else begin
            band = 3'd7;
        end
    end

    always_comb begin
        y_full = EW'(p2_5_reg >> YSH);
        big    = y_full >= EW'(DIV_LIMIT);
        qprod  = QPB'(y6_reg) * QPB'(RECIP_100);
        rem    = y7_reg - Y_BITS'(Y_BITS'(qe7_reg) * Y_BITS'(LUX_DIV));
        // reciprocal estimate is at most one low
        qfix   = qe7_reg + LUX_BITS'(rem >= Y_BITS'(LUX_DIV));
        if (tag_reg[NT-2].sat || zero7_reg) begin
            lux_next = '0;
        end else if (big7_reg) begin
            lux_next = LUX_MAX;
        end else begin
            lux_next = qfix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NT; i++) begin
                tag_reg[i] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < NT; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: band and scaled broadband
            b1_reg     <= coef_b(band);
            m1_reg     <= coef_m(band);
            ratio1_reg <= ratio;
            s0sc1_reg  <= gain_high ? SB'(s0) : (SB'(s0) << GAIN_SHIFT);
            zero1_reg  <= (s0 == '0);
            // stage 2
            hi2_reg    <= KB'(b1_reg) << F;
            lo2_reg    <= MB'(m1_reg) * MB'(ratio1_reg);
            s0sc2_reg  <= s0sc1_reg;
            zero2_reg  <= zero1_reg;
            // stage 3: negative coefficient clamps to zero
            k3_reg     <= ({1'b0, hi2_reg} > lo2_reg) ? KB'({1'b0, hi2_reg} - lo2_reg) : '0;
            s0sc3_reg  <= s0sc2_reg;
            zero3_reg  <= zero2_reg;
            // stage 4
            p1_4_reg   <= P1B'(k3_reg) * P1B'(s0sc3_reg);
            zero4_reg  <= zero3_reg;
            // stage 5
            p2_5_reg   <= P2B'(p1_4_reg) * P2B'(LUX_GAIN);
            zero5_reg  <= zero4_reg;
            // stage 6: drop fraction, catch overflow before the divide
            y6_reg     <= big ? '0 : y_full[Y_BITS-1:0];
            big6_reg   <= big;
            zero6_reg  <= zero5_reg;
            // stage 7
            qe7_reg    <= qprod[RECIP_SHIFT+LUX_BITS-1:RECIP_SHIFT];
            y7_reg     <= y6_reg;
            big7_reg   <= big6_reg;
            zero7_reg  <= zero6_reg;
            // stage 8
            lux8_reg   <= lux_next;
        end
    end

    assign out_tag = tag_reg[NT-1];
    assign lux     = lux8_reg;

endmodule

[sv/two_channel_lux_calculator.sv]
// top level of the two-channel lux calculator: config, pipeline and output register
// pipeline: scaler, ratio divider, lux stages, then the output register, with one divider
// stage per scaled-count and ratio bit
// throughput: one word per cycle; the whole pipeline stalls only while an output word
// waits and the last stage holds a word, otherwise bubbles are squeezed out
// reset: synchronous active-low aresetn clears all valid bits, gain to 1x, time to 13 ms
module two_channel_lux_calculator import tlc_pkg::*; #(
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]             cfg_addr,
    input  logic [TIME_BITS-1:0]                 cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // broadband_count, infrared_count
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // lux
    output logic [LUX_TDATA_BITS-1:0]            m_tdata,
    // sensor_saturated
    output logic [0:0]                           m_tuser
);

    localparam int QB = COUNT_BITS + SCALE_BITS;

    logic                 gain_high_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic                 m_tvalid_reg;
    logic [LUX_BITS-1:0]  lux_reg;
    logic                 sat_reg;

    logic [COUNT_BITS-1:0]  c0, c1;
    logic                   en, out_free;
    tlc_tag_t               in_tag, sc_tag, rt_tag, lux_tag;
    logic [QB-1:0]          s0, s1, s0_rt;
    logic [RATIO_FRAC_BITS:0] ratio;
    logic [LUX_BITS-1:0]    lux;

    // zero integration time is taken as 1 ms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_high_reg <= 1'b0;
            time_reg      <= TIME_BITS'(INTEG_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_GAIN_HIGH: gain_high_reg <= cfg_wdata[0];
                CFG_INTEG_MS:  time_reg <= (cfg_wdata == '0) ? TIME_BITS'(1) : cfg_wdata;
                default: ;
            endcase
        end
    end

    assign c0     = s_tdata[COUNT_BITS-1:0];
    assign c1     = s_tdata[2*COUNT_BITS-1:COUNT_BITS];
    assign in_tag = '{valid: s_tvalid, sat: (c0 == '1) || (c1 == '1)};

    assign out_free = !m_tvalid_reg || m_tready;
    assign en       = out_free || !lux_tag.valid;
    assign s_tready = en;

    tlc_scaler #(
        .COUNT_BITS(COUNT_BITS)
    ) u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (in_tag),
        .c0      (c0),
        .c1      (c1),
        .t       (time_reg),
        .out_tag (sc_tag),
        .s0      (s0),
        .s1      (s1)
    );

    tlc_ratio #(
        .COUNT_BITS      (COUNT_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_ratio (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (sc_tag),
        .s0      (s0),
        .s1      (s1),
        .out_tag (rt_tag),
        .s0_out  (s0_rt),
        .ratio   (ratio)
    );

    tlc_lux #(
        .COUNT_BITS      (COUNT_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_lux (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .gain_high (gain_high_reg),
        .in_tag    (rt_tag),
        .s0        (s0_rt),
        .ratio     (ratio),
        .out_tag   (lux_tag),
        .lux       (lux)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= lux_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            lux_reg <= lux;
            sat_reg <= lux_tag.sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(LUX_TDATA_BITS-LUX_BITS){1'b0}}, lux_reg};
    assign m_tuser  = sat_reg;

    // saturated word always carries zero lux
    a_sat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && sat_reg |-> lux_reg == '0)
        else $error("saturated word with nonzero lux");

    // a waiting output word and a full last stage must freeze the pipeline
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready && lux_tag.valid |-> !s_tready)
        else $error("pipeline advanced over a waiting word");

    // a word leaving the last stage shows up at the output
    a_move_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_free && lux_tag.valid |=> m_tvalid_reg)
        else $error("word lost between last stage and output");

endmodule

[test/two_channel_lux_calculator_test.sv]
// self-checking testbench of the two-channel lux calculator
`timescale 1ns / 1ps

module two_channel_lux_calculator_test;
    import tlc_pkg::*;

    localparam int PIPE_LATENCY = 45;
    localparam logic [15:0] COUNT_FULL = 16'hFFFF;

    typedef struct packed {
        logic [LUX_BITS-1:0] lux;
        logic                sat;
    } lux_reading_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr  = CFG_GAIN_HIGH;
    logic [TIME_BITS-1:0]      cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [31:0]               s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [LUX_TDATA_BITS-1:0] m_tdata;
    logic [0:0]                m_tuser;

    // shadow of the configuration registers
    logic                 gain_high_now = 1'b0;
    logic [TIME_BITS-1:0] integ_ms_now  = TIME_BITS'(INTEG_RESET);

    // Q0.16 intercept and slope per band, Q1.10 upper band limits
    logic [11:0] band_intercept [0:7] = '{1992, 2130, 2300, 2497, 1468, 839, 96, 0};
    logic [11:0] band_slope     [0:7] = '{1783, 2884, 3565, 4089, 2032, 1003, 73, 0};
    logic [10:0] band_limit     [0:6] = '{128, 256, 384, 512, 625, 819, 1331};

    lux_reading_t lux_expected_q[$];
    int           mismatch_count  = 0;
    int           source_idle_pct = 0;
    int           sink_stall_pct  = 0;

    two_channel_lux_calculator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic lux_reading_t lux_predict(logic [15:0] broadband, logic [15:0] infrared);
        lux_reading_t r;
        logic [63:0]  t, s0, s1, ratio, hi, lo, k, lux;
        int           band;
        r = '0;
        if (broadband == COUNT_FULL || infrared == COUNT_FULL) begin
            r.sat = 1'b1;
            return r;
        end
        t  = (integ_ms_now == 0) ? 64'd1 : 64'(integ_ms_now);
        s0 = (64'(broadband) * SCALE_NUM) / t;
        s1 = (64'(infrared) * SCALE_NUM) / t;
        if (!gain_high_now) begin
            s0 = s0 << GAIN_SHIFT;
            s1 = s1 << GAIN_SHIFT;
        end
        if (s0 == 0)
            return r;
        ratio = (s1 << 10) / s0;
        if (ratio > 64'd2047)
            ratio = 64'd2047;
        band = 7;
        for (int i = 6; i >= 0; i--) begin
            if (ratio <= 64'(band_limit[i]))
                band = i;
        end
        hi  = 64'(band_intercept[band]) << 10;
        lo  = 64'(band_slope[band]) * ratio;
        k   = (hi > lo) ? hi - lo : 64'd0;
        lux = (k * s0 * LUX_GAIN) / (64'd100 << 26);
        r.lux = (lux > 64'(LUX_MAX)) ? LUX_MAX : lux[LUX_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // receiver side: random stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        lux_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lux_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word lux %0d sat %0b",
                                          m_tdata[LUX_BITS-1:0], m_tuser[0]));
            end else begin
                want = lux_expected_q.pop_front();
                if (m_tdata[LUX_BITS-1:0] !== want.lux)
                    report_mismatch($sformatf("lux %0d, want %0d",
                                              m_tdata[LUX_BITS-1:0], want.lux));
                if (m_tuser[0] !== want.sat)
                    report_mismatch($sformatf("sensor_saturated %0b, want %0b",
                                              m_tuser[0], want.sat));
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin source_idle_pct = 51; sink_stall_pct = 0;  end
            2: begin source_idle_pct = 0;  sink_stall_pct = 51; end
            default: begin source_idle_pct = 21; sink_stall_pct = 21; end
        endcase
    endtask

    task automatic send_counts(input logic [15:0] broadband, input logic [15:0] infrared);
        while ($urandom_range(99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {infrared, broadband};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        lux_expected_q.push_back(lux_predict(broadband, infrared));
    endtask

    // every word yields one result, so an empty queue means the pipeline is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (lux_expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [TIME_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_GAIN_HIGH)
            gain_high_now = value[0];
        else
            integ_ms_now = value;
        @(posedge aclk);
    endtask

    task automatic set_mode(input logic gain, input logic [TIME_BITS-1:0] integ);
        wait_drained();
        write_cfg(CFG_GAIN_HIGH, TIME_BITS'(gain));
        write_cfg(CFG_INTEG_MS, integ);
    endtask

    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // runs at the reset configuration: 1x gain, 13 ms
    task automatic test_reset_defaults();
        set_idling(0);
        send_counts(16'h0000, 16'h0000);
        send_counts(COUNT_FULL, 16'h0000);
        send_counts(16'h0000, COUNT_FULL);
        send_counts(COUNT_FULL, COUNT_FULL);
        send_counts(16'hFFFE, 16'h0000);
        send_counts(16'hFFFE, 16'hFFFE);
        send_counts(16'h0001, 16'hFFFE);
        send_counts(16'h5555, 16'hAAAA);
    endtask

    // gain 16x and 402 ms make the scaled counts equal the raw ones,
    // so the ratio lands exactly on each band limit and one past it
    task automatic test_band_edges();
        set_mode(1'b1, 9'd402);
        set_idling(3);
        for (int i = 0; i < 7; i++) begin
            send_counts(16'd1024, 16'(band_limit[i]));
            send_counts(16'd1024, 16'(band_limit[i]) + 16'd1);
        end
    endtask

    task automatic test_integration_extremes();
        // time above 402 scales a count of one down to zero broadband
        set_mode(1'b1, 9'd511);
        send_counts(16'h0001, 16'h0000);
        // zero time behaves as 1 ms
        set_mode(1'b0, 9'd0);
        send_counts(16'hFFFE, 16'h1000);
    endtask

    task automatic random_counts(output logic [15:0] broadband, output logic [15:0] infrared);
        logic [31:0] scaled;
        case ($urandom_range(9))
            0: begin
                broadband = 16'($urandom_range(16'hFFFF));
                infrared  = 16'($urandom_range(16'hFFFF));
                if ($urandom_range(1))
                    broadband = COUNT_FULL;
                else
                    infrared = COUNT_FULL;
            end
            1, 2: begin
                broadband = 16'($urandom_range(16'hFFFF));
                infrared  = 16'($urandom_range(16'hFFFF));
            end
            7: begin
                broadband = 16'($urandom_range(15));
                infrared  = 16'($urandom_range(15));
            end
            8: begin
                broadband = 16'($urandom_range(255));
                infrared  = 16'($urandom_range(16'hFFFE, 256));
            end
            default: begin
                // infrared as a random fraction of broadband sweeps all bands
                broadband = 16'($urandom_range(16'hFFFE));
                scaled    = (32'(broadband) * $urandom_range(1400)) >> 10;
                infrared  = (scaled > 32'hFFFE) ? 16'hFFFE : scaled[15:0];
            end
        endcase
    endtask

    task automatic test_random_settings();
        logic                 gain_list  [0:8] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
        logic [TIME_BITS-1:0] integ_list [0:8] = '{13, 402, 1, 1, 402, 511, 0, 0, 0};
        logic [15:0]          broadband, infrared;
        for (int p = 0; p < 9; p++) begin
            if (p >= 7)
                integ_list[p] = TIME_BITS'($urandom_range(511, 1));
            set_mode(gain_list[p], integ_list[p]);
            set_idling(p % 4);
            repeat (150) begin
                random_counts(broadband, infrared);
                send_counts(broadband, infrared);
            end
        end
    endtask

    initial begin
        apply_reset();
        test_reset_defaults();
        test_band_edges();
        test_integration_extremes();
        test_random_settings();
        wait_drained();
        repeat (PIPE_LATENCY + 20) @(posedge aclk);
        if (mismatch_count == 0 && lux_expected_q.size() == 0)
            $display("two_channel_lux_calculator regression: pass");
        else
            $display("two_channel_lux_calculator regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("two_channel_lux_calculator regression: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/tlc_pkg.sv
sv/tlc_scaler.sv
sv/tlc_ratio.sv
sv/tlc_lux.sv
sv/two_channel_lux_calculator.sv
test/two_channel_lux_calculator_test.sv
